[hw/rtl/stable_matching_engine_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the stable matching engine
// Property forms used by the smeu_core module of the block.
// ----------------------------------------------------------------------------
`ifndef STABLE_MATCHING_ENGINE_UNIT_ASSERT_SVH
`define STABLE_MATCHING_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SMEU_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMEU_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/smeu_pkg.sv]
// ----------------------------------------------------------------------------
// smeu_pkg
// Types and constants shared by the stable matching engine modules.
// ----------------------------------------------------------------------------
package smeu_pkg;

  // Person, rank and choice indices are three bits wide.
  localparam int IDX_W  = 3;
  localparam int ADDR_W = 2 * IDX_W;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] taddr_t;

  // Entry kinds of a load beat.
  localparam logic OP_PROPOSER = 1'b0;
  localparam logic OP_ACCEPTOR = 1'b1;

  // Write port of the preference tables.
  typedef struct packed {
    logic   pref_en;
    logic   rank_en;
    taddr_t addr;
    idx_t   data;
  } tbl_wr_t;

  // Read addresses of the preference tables.
  typedef struct packed {
    taddr_t pref_addr;
    taddr_t rank_addr;
  } tbl_rd_t;

endpackage

[hw/rtl/smeu_tables.sv]
// ----------------------------------------------------------------------------
// smeu_tables
// Proposer preference memory and inverted acceptor rank memory, each with
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module smeu_tables (
  input  logic              clk,
  input  smeu_pkg::tbl_wr_t wr,
  input  smeu_pkg::tbl_rd_t rd,
  output smeu_pkg::idx_t    pref_q,
  output smeu_pkg::idx_t    rank_q
);
  import smeu_pkg::*;

  localparam int DEPTH = 2 ** ADDR_W;

  idx_t pref_mem [DEPTH];
  idx_t rank_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.pref_en) begin
      pref_mem[wr.addr] <= wr.data;
    end
    if (wr.rank_en) begin
      rank_mem[wr.addr] <= wr.data;
    end
    pref_q <= pref_mem[rd.pref_addr];
    rank_q <= rank_mem[rd.rank_addr];
  end

endmodule

[hw/rtl/smeu_core.sv]
// ----------------------------------------------------------------------------
// smeu_core
// Gale-Shapley sequencer: free-proposer queue, engagement state, and the
// result sweep over all proposers.
// ----------------------------------------------------------------------------
`include "stable_matching_engine_unit_assert.svh"

module smeu_core #(
  parameter int ACTIVE = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  output logic              busy,
  output smeu_pkg::tbl_rd_t rd,
  input  smeu_pkg::idx_t    pref_q,
  input  smeu_pkg::idx_t    rank_q,
  output logic              result_valid,
  output smeu_pkg::idx_t    proposer,
  output smeu_pkg::idx_t    partner,
  output logic              matched,
  output logic              final_res
);
  import smeu_pkg::*;

  localparam int AW = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
  localparam int CW = $clog2(ACTIVE + 1);
  localparam logic [CW-1:0] ACT_C  = CW'(ACTIVE);
  localparam logic [CW:0]   ACT_S  = (CW + 1)'(ACTIVE);
  localparam logic [AW-1:0] LAST_P = AW'(ACTIVE - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_INIT, ST_FETCH, ST_CHECK, ST_PREF, ST_RK1, ST_RK2, ST_OUT
  } state_t;

  state_t state;

  logic [ACTIVE-1:0] ap_valid;
  idx_t              ap_idx [ACTIVE];
  logic [ACTIVE-1:0] pp_valid;
  idx_t              pp_idx [ACTIVE];
  logic [CW-1:0]     made   [ACTIVE];
  idx_t              queue  [ACTIVE];
  logic [AW-1:0]     head;
  logic [CW-1:0]     count;
  idx_t              m;
  idx_t              w;
  idx_t              cur;
  idx_t              rank_m;
  logic [AW-1:0]     out_p;

  logic [AW-1:0] m_a;
  logic [AW-1:0] w_a;
  logic [AW-1:0] cur_a;
  logic [AW-1:0] pref_a;
  logic [CW-1:0] made_m;
  logic [CW-1:0] made_inc;
  logic [AW-1:0] head_inc;
  logic [CW:0]   tail_sum;
  logic [AW-1:0] tail_a;

  assign m_a      = m[AW-1:0];
  assign w_a      = w[AW-1:0];
  assign cur_a    = cur[AW-1:0];
  assign pref_a   = pref_q[AW-1:0];
  assign made_m   = made[m_a];
  assign made_inc = made_m + 1'b1;
  assign head_inc = (head == LAST_P) ? '0 : head + 1'b1;
  assign tail_sum = (CW + 1)'(head) + (CW + 1)'(count);
  assign tail_a   = (tail_sum >= ACT_S) ? AW'(tail_sum - ACT_S) : AW'(tail_sum);

  // The preference read is issued in the check state; the rank reads go
  // out first for the new proposer, then for the incumbent.
  assign rd.pref_addr = {m, IDX_W'(made_m)};
  assign rd.rank_addr = (state == ST_PREF) ? {pref_q, m} : {w, cur};

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      head         <= '0;
      count        <= '0;
      ap_valid     <= '0;
      pp_valid     <= '0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (go) begin
            state <= ST_INIT;
          end
        end
        ST_INIT: begin
          ap_valid <= '0;
          pp_valid <= '0;
          for (int i = 0; i < ACTIVE; i++) begin
            made[i]  <= '0;
            queue[i] <= IDX_W'(i);
          end
          head  <= '0;
          count <= ACT_C;
          state <= ST_FETCH;
        end
        ST_FETCH: begin
          if (count == '0) begin
            out_p <= '0;
            state <= ST_OUT;
          end else begin
            m     <= queue[head];
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (made_m >= ACT_C) begin
            head  <= head_inc;
            count <= count - 1'b1;
            state <= ST_FETCH;
          end else begin
            state <= ST_PREF;
          end
        end
        ST_PREF: begin
          w   <= pref_q;
          cur <= ap_idx[pref_a];
          if (!ap_valid[pref_a]) begin
            ap_valid[pref_a] <= 1'b1;
            ap_idx[pref_a]   <= m;
            pp_valid[m_a]    <= 1'b1;
            pp_idx[m_a]      <= pref_q;
            made[m_a]        <= made_inc;
            head             <= head_inc;
            count            <= count - 1'b1;
            state            <= ST_FETCH;
          end else begin
            state <= ST_RK1;
          end
        end
        ST_RK1: begin
          rank_m <= rank_q;
          state  <= ST_RK2;
        end
        ST_RK2: begin
          made[m_a] <= made_inc;
          if (rank_m < rank_q) begin
            // Trade up: the incumbent goes back to the tail of the queue.
            ap_idx[w_a]     <= m;
            pp_valid[m_a]   <= 1'b1;
            pp_idx[m_a]     <= w;
            pp_valid[cur_a] <= 1'b0;
            queue[tail_a]   <= cur;
            head            <= head_inc;
            state           <= ST_FETCH;
          end else begin
            state <= ST_CHECK;
          end
        end
        ST_OUT: begin
          result_valid <= 1'b1;
          proposer     <= IDX_W'(out_p);
          partner      <= pp_valid[out_p] ? pp_idx[out_p] : '0;
          matched      <= pp_valid[out_p];
          final_res    <= (out_p == LAST_P);
          if (out_p == LAST_P) begin
            state <= ST_IDLE;
          end else begin
            out_p <= out_p + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SMEU_ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, count <= ACT_C,
                       "free queue overflow")
  `SMEU_ASSERT_IMPLIES(a_list_left, clk, rst,
                       state == ST_PREF || state == ST_RK1 || state == ST_RK2,
                       made_m < ACT_C, "proposal past the end of a list")
  `SMEU_ASSERT_IMPLIES(a_result_src, clk, rst, result_valid, $past(state == ST_OUT),
                       "result outside the output sweep")
  `SMEU_ASSERT_IMPLIES(a_final_idle, clk, rst, result_valid && final_res,
                       state == ST_IDLE, "run not closed after final result")
  `SMEU_ASSERT_NEXT(a_go_init, clk, rst, state == ST_IDLE && go, state == ST_INIT,
                    "run start missed")

endmodule

[hw/rtl/stable_matching_engine_unit.sv]
// ----------------------------------------------------------------------------
// stable_matching_engine_unit
// Loads two preference tables and computes a proposer-optimal stable matching.
// ----------------------------------------------------------------------------
// Usage. Each beat on the command channel (start high while busy is low)
// loads one table entry: op selects a proposer entry, stored as the choice at
// a rank of that proposer's list, or an acceptor entry, stored inverted as the
// rank that acceptor gives the chosen proposer. Entries with an index beyond
// the active size are dropped. Busy stays low during a load.
// A beat with last set is stored and then starts a matching run; busy rises
// on the next cycle and falls with the last result beat. The run first
// clears the run state, then each proposal takes a list check and a
// preference read when the acceptor is free, and also two rank reads when she
// is engaged, one after the other through the single read port of the rank
// memory. Each proposer taken from the queue takes a fetch step, and a
// proposer whose list runs out one more check step. There are at most
// N squared proposals for N active people.
// The run ends with N result beats on consecutive cycles, one per proposer in
// index order, each marked by result_valid for one cycle and final_res on the
// last. The receiver cannot stall; results are never held back.
// Reset returns the sequencer to idle with no result pending; the tables are
// not cleared and must be loaded before the first run.
// ----------------------------------------------------------------------------
module stable_matching_engine_unit #(
  parameter int PEOPLE = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  logic           op,
  input  smeu_pkg::idx_t person,
  input  smeu_pkg::idx_t rank,
  input  smeu_pkg::idx_t choice,
  input  logic           last,
  output logic           result_valid,
  output smeu_pkg::idx_t proposer,
  output smeu_pkg::idx_t partner,
  output logic           matched,
  output logic           final_res
);
  import smeu_pkg::*;

  // The index fields are three bits wide, so at most eight people take part.
  localparam int ACTIVE = (PEOPLE < 8) ? PEOPLE : 8;
  localparam logic [IDX_W:0] ACT_V = (IDX_W + 1)'(ACTIVE);

  logic    accept;
  logic    in_range;
  tbl_wr_t wr;
  tbl_rd_t rd;
  idx_t    pref_q;
  idx_t    rank_q;

  assign accept   = start & ~busy;
  assign in_range = ({1'b0, person} < ACT_V) && ({1'b0, rank} < ACT_V)
                    && ({1'b0, choice} < ACT_V);

  // Proposer entries are addressed by rank; acceptor entries are inverted
  // and addressed by the proposer they rank.
  assign wr.pref_en = accept & in_range & (op == OP_PROPOSER);
  assign wr.rank_en = accept & in_range & (op == OP_ACCEPTOR);
  assign wr.addr    = (op == OP_PROPOSER) ? {person, rank} : {person, choice};
  assign wr.data    = (op == OP_PROPOSER) ? choice : rank;

  smeu_tables u_tables (
    .clk    (clk),
    .wr     (wr),
    .rd     (rd),
    .pref_q (pref_q),
    .rank_q (rank_q)
  );

  smeu_core #(
    .ACTIVE (ACTIVE)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .go           (accept & last),
    .busy         (busy),
    .rd           (rd),
    .pref_q       (pref_q),
    .rank_q       (rank_q),
    .result_valid (result_valid),
    .proposer     (proposer),
    .partner      (partner),
    .matched      (matched),
    .final_res    (final_res)
  );

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stable matching engine testbench
// Loads preference tables through the command port. On every beat with last
// set, the testbench computes the proposer-optimal Gale-Shapley matching
// itself and checks the eight pairing beats that the engine returns.
// ----------------------------------------------------------------------------
module testbench;

  import smeu_pkg::*;

  localparam int PEOPLE_N = 8;
  // The index fields are three bits wide, so at most eight people take part.
  localparam int ACTIVE = (PEOPLE_N < 8) ? PEOPLE_N : 8;
  // Cycle limit. The slowest run is N squared proposals, each with both rank
  // reads, plus fetches and checks. A handful of runs and about 150 load beats
  // with sender gaps fit within the limit many times over.
  localparam int CYCLE_LIMIT = 200000;

  // One load beat as the sender presents it, with its gap odds. When
  // wait_drain is set, the sender holds this beat back until every pairing
  // it already expects has come out.
  typedef struct {
    logic        op;
    idx_t        person;
    idx_t        rank;
    idx_t        choice;
    logic        last;
    int unsigned gap_pct;
    bit          wait_drain;
  } load_beat_t;

  // One pairing beat of a matching run.
  typedef struct {
    idx_t proposer;
    idx_t partner;
    logic matched;
    logic final_res;
  } pairing_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic op = OP_PROPOSER;
  idx_t person = '0;
  idx_t rank = '0;
  idx_t choice = '0;
  logic last = 1'b0;
  logic busy;
  logic result_valid;
  idx_t proposer;
  idx_t partner;
  logic matched;
  logic final_res;

  // Beats still to be sent, and pairings still to be seen.
  load_beat_t pending_loads[$];
  pairing_t   expected_pairs[$];
  load_beat_t on_port;

  // The testbench's own copy of the two tables. The acceptor table is kept
  // inverted, as the engine keeps it: acceptor_rank[a][p] is the rank that
  // acceptor a gives proposer p.
  idx_t proposer_choice [ACTIVE][ACTIVE];
  idx_t acceptor_rank   [ACTIVE][ACTIVE];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned cur_gap_pct;
  bit          drain_next;

  stable_matching_engine_unit #(
    .PEOPLE(PEOPLE_N)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .person      (person),
    .rank        (rank),
    .choice      (choice),
    .last        (last),
    .result_valid(result_valid),
    .proposer    (proposer),
    .partner     (partner),
    .matched     (matched),
    .final_res   (final_res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t MISMATCH %s", $realtime, what);
  endtask

  // Stores one accepted load beat in the table copies. Entries with an index
  // at or beyond the active size are dropped, as the engine drops them.
  task automatic store_entry(input load_beat_t b);
    if (b.person < ACTIVE && b.rank < ACTIVE && b.choice < ACTIVE) begin
      if (b.op == OP_PROPOSER) begin
        proposer_choice[b.person][b.rank] = b.choice;
      end else begin
        acceptor_rank[b.person][b.choice] = b.rank;
      end
    end
  endtask

  // Proposer-optimal matching over the current tables. Free proposers wait
  // in a circular FIFO; the one at the head proposes down his list until he
  // is engaged or his list runs out. An acceptor trades up only for a strictly
  // better rank, and the displaced proposer goes to the tail of the FIFO.
  task automatic predict_stable_pairs();
    idx_t     free_fifo [ACTIVE];
    bit       acc_taken [ACTIVE];
    idx_t     acc_with  [ACTIVE];
    bit       prop_taken [ACTIVE];
    idx_t     prop_with  [ACTIVE];
    int       proposals [ACTIVE];
    int       head;
    int       count;
    int       m;
    int       w;
    int       cur;
    pairing_t pair;
    for (int i = 0; i < ACTIVE; i++) begin
      free_fifo[i]  = idx_t'(i);
      acc_taken[i]  = 1'b0;
      acc_with[i]   = '0;
      prop_taken[i] = 1'b0;
      prop_with[i]  = '0;
      proposals[i]  = 0;
    end
    head  = 0;
    count = ACTIVE;
    while (count != 0) begin
      m = free_fifo[head];
      while (proposals[m] < ACTIVE && !prop_taken[m]) begin
        w = proposer_choice[m][proposals[m]];
        if (!acc_taken[w]) begin
          acc_taken[w]  = 1'b1;
          acc_with[w]   = idx_t'(m);
          prop_taken[m] = 1'b1;
          prop_with[m]  = idx_t'(w);
          head  = (head + 1) % ACTIVE;
          count = count - 1;
        end else begin
          cur = acc_with[w];
          // A tie leaves the incumbent in place.
          if (acceptor_rank[w][m] < acceptor_rank[w][cur]) begin
            acc_with[w]     = idx_t'(m);
            prop_taken[m]   = 1'b1;
            prop_with[m]    = idx_t'(w);
            prop_taken[cur] = 1'b0;
            prop_with[cur]  = '0;
            head  = (head + 1) % ACTIVE;
            count = count - 1;
            free_fifo[(head + count) % ACTIVE] = idx_t'(cur);
            count = count + 1;
          end
        end
        proposals[m]++;
      end
      // A proposer whose list ran out leaves the FIFO unmatched.
      if (!prop_taken[m]) begin
        head  = (head + 1) % ACTIVE;
        count = count - 1;
      end
    end
    for (int p = 0; p < ACTIVE; p++) begin
      pair.proposer  = idx_t'(p);
      pair.partner   = prop_taken[p] ? prop_with[p] : idx_t'(0);
      pair.matched   = prop_taken[p];
      pair.final_res = (p == ACTIVE - 1);
      expected_pairs.push_back(pair);
    end
  endtask

  // Driver. A beat is taken at an edge where start is high and busy low; the
  // table copies are updated right there, and a beat with last set produces
  // its eight expected pairings before anything else can be sent. The next
  // beat is chosen once per edge and driven with a single assignment to each
  // port, so start stays high across back-to-back beats.
  always @(posedge clk) begin
    if (rst) begin
      start  <= 1'b0;
      op     <= OP_PROPOSER;
      person <= '0;
      rank   <= '0;
      choice <= '0;
      last   <= 1'b0;
    end else begin
      if (start && !busy) begin
        store_entry(on_port);
        if (on_port.last) begin
          predict_stable_pairs();
        end
      end
      if (!start || !busy) begin
        if (pending_loads.size() > 0 &&
            (!pending_loads[0].wait_drain || expected_pairs.size() == 0) &&
            $urandom_range(0, 99) >= pending_loads[0].gap_pct) begin
          on_port = pending_loads.pop_front();
          start  <= 1'b1;
          op     <= on_port.op;
          person <= on_port.person;
          rank   <= on_port.rank;
          choice <= on_port.choice;
          last   <= on_port.last;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every pairing beat is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_pairs.size() == 0) begin
        report_mismatch($sformatf("unexpected pairing beat for proposer %0d", proposer));
      end else begin
        if (proposer !== expected_pairs[0].proposer) begin
          report_mismatch($sformatf("proposer %0d, want %0d",
                                    proposer, expected_pairs[0].proposer));
        end
        if (partner !== expected_pairs[0].partner) begin
          report_mismatch($sformatf("proposer %0d partner %0d, want %0d",
                                    expected_pairs[0].proposer, partner,
                                    expected_pairs[0].partner));
        end
        if (matched !== expected_pairs[0].matched) begin
          report_mismatch($sformatf("proposer %0d matched %0b, want %0b",
                                    expected_pairs[0].proposer, matched,
                                    expected_pairs[0].matched));
        end
        if (final_res !== expected_pairs[0].final_res) begin
          report_mismatch($sformatf("proposer %0d final_res %0b, want %0b",
                                    expected_pairs[0].proposer, final_res,
                                    expected_pairs[0].final_res));
        end
        void'(expected_pairs.pop_front());
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic queue_beat(input logic b_op, input int b_person, input int b_rank,
                            input int b_choice, input logic b_last);
    load_beat_t b;
    b.op         = b_op;
    b.person     = idx_t'(b_person);
    b.rank       = idx_t'(b_rank);
    b.choice     = idx_t'(b_choice);
    b.last       = b_last;
    b.gap_pct    = cur_gap_pct;
    b.wait_drain = drain_next;
    drain_next   = 1'b0;
    pending_loads.push_back(b);
  endtask

  // Queues a whole list for one person as a random permutation, so that the
  // list names every partner exactly once.
  task automatic queue_list(input logic l_op, input int who, input logic last_at_end);
    int order [ACTIVE];
    int j;
    int t;
    for (int i = 0; i < ACTIVE; i++) begin
      order[i] = i;
    end
    for (int i = ACTIVE - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int r = 0; r < ACTIVE; r++) begin
      queue_beat(l_op, who, r, order[r], last_at_end && (r == ACTIVE - 1));
    end
  endtask

  initial begin
    int noise;
    cur_gap_pct = 25;
    drain_next  = 1'b0;

    // Every entry of both tables is written before the first run, so no run
    // ever reads an entry that was never loaded. These lists also carry the
    // extremes of every field for both entry kinds. The final beat starts the
    // first run.
    for (int p = 0; p < ACTIVE; p++) begin
      queue_list(OP_PROPOSER, p, 1'b0);
    end
    for (int a = 0; a < ACTIVE; a++) begin
      queue_list(OP_ACCEPTOR, a, a == ACTIVE - 1);
    end

    // Proposer 0 names acceptor 0 first, proposer 1 names her at every rank,
    // and she ranks both of them first. Proposer 0 reaches her first and no
    // one outranks him, so he keeps her through the tie and proposer 1 runs
    // out of list and must come back unmatched.
    queue_beat(OP_PROPOSER, 0, 0, 0, 1'b0);
    for (int r = 0; r < ACTIVE; r++) begin
      queue_beat(OP_PROPOSER, 1, r, 0, 1'b0);
    end
    queue_beat(OP_ACCEPTOR, 0, 0, 0, 1'b0);
    queue_beat(OP_ACCEPTOR, 0, 0, 1, 1'b1);

    // Random part: two runs, each after either one list reloaded as a fresh
    // permutation or a handful of arbitrary entries, which leave duplicates in
    // lists and ties in ranks behind. The first is sent with gaps in half the
    // cycles; the second starts by waiting for every pairing to drain and is
    // then sent with no gaps.
    for (int part = 0; part < 2; part++) begin
      if (part == 0) begin
        cur_gap_pct = 50;
      end else begin
        drain_next  = 1'b1;
        cur_gap_pct = 0;
      end
      if ($urandom_range(0, 99) < 60) begin
        queue_list($urandom_range(0, 1) ? OP_ACCEPTOR : OP_PROPOSER,
                   $urandom_range(0, ACTIVE - 1), 1'b1);
      end else begin
        noise = $urandom_range(1, 6);
        for (int k = 0; k < noise; k++) begin
          queue_beat($urandom_range(0, 1) ? OP_ACCEPTOR : OP_PROPOSER,
                     $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
                     k == noise - 1);
        end
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last beat to be taken, then for every pairing to arrive,
    // and give the engine a little longer to show any stray beat.
    while (pending_loads.size() != 0 || start) begin
      @(posedge clk);
    end
    while (expected_pairs.size() != 0) begin
      @(posedge clk);
    end
    repeat (50) @(posedge clk);

    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
